// File: sv/pf_pkg.sv
// pf_pkg: microcode step codes, control word type and program rom for the factorizer
// no dependencies
package pf_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);
  localparam int unsigned STEP_W      = 4;

  localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CHK_SMALL = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SQUARE    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_TEST      = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DIV_INIT  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DIV_STEP  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_CHK_REM   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT_FAC  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_INC       = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT_LAST = 4'd9;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_IDLE,
    OP_SQUARE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT_FAC,
    OP_INC,
    OP_EMIT_LAST
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_START,
    C_SMALL,
    C_STOP,
    C_DIV_RUN,
    C_REM_NZ
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE:      w = '{op: OP_IDLE,      cond: C_NO_START, target: STEP_IDLE};
      STEP_CHK_SMALL: w = '{op: OP_NONE,      cond: C_SMALL,    target: STEP_EMIT_LAST};
      STEP_SQUARE:    w = '{op: OP_SQUARE,    cond: C_NEXT,     target: STEP_IDLE};
      STEP_TEST:      w = '{op: OP_NONE,      cond: C_STOP,     target: STEP_EMIT_LAST};
      STEP_DIV_INIT:  w = '{op: OP_DIV_INIT,  cond: C_NEXT,     target: STEP_IDLE};
      STEP_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_RUN,  target: STEP_DIV_STEP};
      STEP_CHK_REM:   w = '{op: OP_NONE,      cond: C_REM_NZ,   target: STEP_INC};
      STEP_EMIT_FAC:  w = '{op: OP_EMIT_FAC,  cond: C_ALWAYS,   target: STEP_SQUARE};
      STEP_INC:       w = '{op: OP_INC,       cond: C_ALWAYS,   target: STEP_SQUARE};
      STEP_EMIT_LAST: w = '{op: OP_EMIT_LAST, cond: C_ALWAYS,   target: STEP_IDLE};
      default:        w = '{op: OP_NONE,      cond: C_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: sv/prime_factorizer.sv
// prime_factorizer: trial-division factorizer run by a microcoded sequencer
// depends on pf_pkg (step codes, control word type, program rom)
//
// usage: drive value_i and pulse start while busy is low; the request is taken at
// that edge. the block then emits the prime factors of value_i in nondecreasing
// order, one per cycle-wide pulse of valid_o on factor_o, with last_o set on the
// final one. values 0 and 1 come back unchanged as a single result with last_o.
// at most 16 results per value; a 16th carries the whole remaining cofactor.
// each trial divisor runs a square, a test, and a restoring divider that retires
// one quotient bit per cycle; on a trial that finds a factor, the emit step takes
// the place of the increment. a 16-bit prime near 65535 takes about 256 trials.
// the shared one-bit-per-cycle divider sets the pace. busy drops in the cycle the
// last result is shown, so the next request may be taken while that result is
// still on the outputs.
// results cannot be held off: each is valid for exactly one cycle.
// reset returns the sequencer to idle and clears valid_o; no request is kept.
module prime_factorizer #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   valid_o,
  output logic [VALUE_WIDTH-1:0] factor_o,
  output logic                   last_o
);
  import pf_pkg::*;

  localparam int unsigned W      = VALUE_WIDTH;
  localparam int unsigned W2     = 2 * VALUE_WIDTH;
  localparam int unsigned DCNT_W = $clog2(VALUE_WIDTH);

  logic [STEP_W-1:0] pc_q, pc_d;
  ctrl_word_t        cw;
  logic              jump;

  logic [W-1:0]      rem_q;
  logic [W-1:0]      div_q;
  logic [W2-1:0]     sq_q;
  logic [W-1:0]      part_q;
  logic [W-1:0]      quo_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [CNT_W-1:0]  n_q;
  logic              valid_q;
  logic [W-1:0]      factor_q;
  logic              last_q;

  logic [W:0]        shifted;
  logic [W:0]        diff;
  logic              accept;

  assign cw     = rom(pc_q);
  assign busy   = (pc_q != STEP_IDLE);
  assign accept = start && !busy;

  always_comb begin
    unique case (cw.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_START: jump = !start;
      C_SMALL:    jump = (rem_q < W'(2));
      C_STOP:     jump = (sq_q > W2'(rem_q)) || (n_q == CNT_W'(MAX_RESULTS - 1));
      C_DIV_RUN:  jump = (dcnt_q != '0);
      C_REM_NZ:   jump = (part_q != '0);
      default:    jump = 1'b1;
    endcase
    pc_d = jump ? cw.target : pc_q + STEP_W'(1);
  end

  // one restoring division step
  assign shifted = {part_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= STEP_IDLE;
      valid_q <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      valid_q <= (cw.op == OP_EMIT_FAC) || (cw.op == OP_EMIT_LAST);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cw.op)
      OP_IDLE: begin
        if (accept) begin
          rem_q <= value_i;
          div_q <= W'(2);
          n_q   <= '0;
        end
      end
      OP_SQUARE: begin
        sq_q <= W2'(div_q) * W2'(div_q);
      end
      OP_DIV_INIT: begin
        part_q <= '0;
        quo_q  <= rem_q;
        dcnt_q <= DCNT_W'(W - 1);
      end
      OP_DIV_STEP: begin
        if (!diff[W]) begin
          part_q <= diff[W-1:0];
          quo_q  <= {quo_q[W-2:0], 1'b1};
        end else begin
          part_q <= shifted[W-1:0];
          quo_q  <= {quo_q[W-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - DCNT_W'(1);
      end
      OP_EMIT_FAC: begin
        factor_q <= div_q;
        last_q   <= 1'b0;
        rem_q    <= quo_q;
        n_q      <= n_q + CNT_W'(1);
      end
      OP_INC: begin
        div_q <= div_q + W'(1);
      end
      OP_EMIT_LAST: begin
        factor_q <= rem_q;
        last_q   <= 1'b1;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign valid_o  = valid_q;
  assign factor_o = factor_q;
  assign last_o   = last_q;

endmodule

// File: sim/testbench.sv
// testbench: self-checking bench for prime_factorizer, directed values then random ones
// depends on sv/pf_pkg.sv and sv/prime_factorizer.sv; predicts factor lists by trial division
// and compares every result strobe in order; sender idling changes over three phases
module testbench;

  localparam int unsigned VW          = 16;
  localparam int unsigned N_RANDOM    = 120;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_WAIT  = 64;

  typedef struct packed {
    logic [VW-1:0] factor;
    logic          last;
  } factor_rec_t;

  logic          clk_i   = 1'b0;
  logic          rst_ni  = 1'b0;
  logic          start   = 1'b0;
  logic [VW-1:0] value_i = '0;
  logic          busy;
  logic          valid_o;
  logic [VW-1:0] factor_o;
  logic          last_o;

  logic [VW-1:0] pending_values[$];
  factor_rec_t   expected_factors[$];
  int unsigned   n_total      = 0;
  int unsigned   n_directed   = 0;
  int unsigned   n_accepted   = 0;
  int unsigned   n_checked    = 0;
  int unsigned   n_mismatch   = 0;
  int unsigned   most_factors = 0;
  int unsigned   cycle_count  = 0;

  prime_factorizer #(.VALUE_WIDTH(VW)) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .value_i  (value_i),
    .valid_o  (valid_o),
    .factor_o (factor_o),
    .last_o   (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // trial division from the smallest divisor, capped at the result limit
  function automatic void predict_factors(input logic [VW-1:0] v);
    longint unsigned rem;
    longint unsigned d;
    int unsigned     n;
    rem = v;
    d   = 2;
    n   = 0;
    if (rem < 2) begin
      expected_factors.push_back('{factor: v, last: 1'b1});
      n = 0;
    end else begin
      while (d * d <= rem && n < pf_pkg::MAX_RESULTS - 1) begin
        if (rem % d == 0) begin
          expected_factors.push_back('{factor: VW'(d), last: 1'b0});
          n++;
          rem = rem / d;
        end else begin
          d++;
        end
      end
      expected_factors.push_back('{factor: VW'(rem), last: 1'b1});
    end
    if (n + 1 > most_factors) most_factors = n + 1;
  endfunction

  // request driver
  always @(posedge clk_i) begin : drive_requests
    logic          next_start;
    logic [VW-1:0] next_value;
    int unsigned   idle_pct;
    if (rst_ni) begin
      next_start = start;
      next_value = value_i;
      if (n_accepted < n_total / 3) idle_pct = 18;
      else if (n_accepted < 2 * n_total / 3) idle_pct = 58;
      else idle_pct = 0;
      if (start && !busy) begin
        predict_factors(value_i);
        n_accepted++;
        next_start = 1'b0;
        next_value = VW'($urandom);
      end
      if (!next_start && pending_values.size() > 0 && $urandom_range(99) >= idle_pct) begin
        next_value = pending_values.pop_front();
        next_start = 1'b1;
      end
      start   <= next_start;
      value_i <= next_value;
    end
  end

  // result monitor
  always @(posedge clk_i) begin : check_results
    factor_rec_t want;
    if (rst_ni && valid_o) begin
      if (expected_factors.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: factor %0d last %0b", factor_o, last_o);
      end else begin
        want = expected_factors.pop_front();
        n_checked++;
        if (factor_o !== want.factor || last_o !== want.last) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected factor %0d last %0b, got factor %0d last %0b",
                     want.factor, want.last, factor_o, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [VW-1:0] directed[$];
    int unsigned   v;
    int unsigned   f;
    int unsigned   d;
    // edge values, primes, prime powers, squares and the longest factor chain
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd12, 16'd49, 16'd1024,
                 16'd4093, 16'd30030, 16'd21845, 16'd43690, 16'd32768, 16'd63001,
                 16'd64009, 16'd65025, 16'd65521, 16'd65534, 16'd65535};
    foreach (directed[i]) pending_values.push_back(directed[i]);
    n_directed = directed.size();
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(9))
        5, 6: v = $urandom_range(255);
        7, 8: begin
          v = 1;
          for (int k = 0; k < 16; k++) begin
            f = $urandom_range(13, 2);
            if (v * f <= 65535) v = v * f;
          end
        end
        9: begin
          d = $urandom_range(255, 2);
          v = d * d;
        end
        default: v = $urandom_range(65535, 2);
      endcase
      pending_values.push_back(VW'(v));
    end
    n_total = pending_values.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total || expected_factors.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("factored %0d values (%0d directed, %0d random), checked %0d factors",
             n_accepted, n_directed, n_total - n_directed, n_checked);
    $display("longest factor list %0d, sender idle 18%% then 58%% then none, %0d mismatches",
             most_factors, n_mismatch);
    if (n_mismatch == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
sv/pf_pkg.sv
sv/prime_factorizer.sv
sim/testbench.sv
